[hw/rtl/twd_pkg.sv]
`default_nettype none
// ============================================================================
// twd_pkg
// Shared sizes, command codes and payload types of the dictionary trie.
// ============================================================================
package twd_pkg;

    // Node pool and alphabet
    localparam int unsigned NODE_COUNT    = 1024;
    localparam int unsigned ALPHABET_SIZE = 26;

    localparam int unsigned NODE_W  = $clog2(NODE_COUNT);
    localparam int unsigned POOL_W  = NODE_W + 1;
    localparam int unsigned SLOTS   = NODE_COUNT * ALPHABET_SIZE;
    localparam int unsigned SLOT_W  = $clog2(SLOTS);

    // Fixed field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned LETTER_W = 5;

    // Command codes (anything else acts as a prefix test)
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } twd_req_t;

    typedef struct packed {
        logic hit;
        logic overflow;
    } twd_res_t;

    // Controller to datapath
    typedef struct packed {
        logic sweep;    // clear one table entry
        logic accept;   // take a request, start the child read
        logic resolve;  // child read back: step or allocate
        logic commit;   // load the result, mark the word, return to root
    } twd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;  // final entry of the clearing pass
        logic in_skip;     // incoming letter needs no lookup
        logic in_last;     // incoming letter ends the word
        logic item_last;   // held letter ends the word
        logic out_free;    // result register can take a result
    } twd_status_t;

endpackage
`default_nettype wire

[hw/rtl/twd_ram.sv]
`default_nettype none
// ============================================================================
// twd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module twd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hw/rtl/twd_ctrl.sv]
`default_nettype none
// ============================================================================
// twd_ctrl
// Sequencer for the dictionary trie: clearing pass, lookup, result.
// ============================================================================
module twd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire twd_pkg::twd_status_t status,
    output twd_pkg::twd_cmd_t         cmd
);
    import twd_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!status.in_skip) begin
                        state_next = ST_LOOKUP;
                    end else if (status.in_last) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_LOOKUP: begin
                cmd.resolve = 1'b1;
                state_next  = status.item_last ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule
`default_nettype wire

[hw/rtl/twd_datapath.sv]
`default_nettype none
// ============================================================================
// twd_datapath
// Walk registers, node pool, child and word-mark tables, result register.
// ============================================================================
module twd_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire twd_pkg::twd_req_t    s_req,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output twd_pkg::twd_res_t         m_res,
    input  wire twd_pkg::twd_cmd_t    cmd,
    output twd_pkg::twd_status_t      status
);
    import twd_pkg::*;

    // walk state
    logic [NODE_W-1:0] node_reg, node_next;
    logic [POOL_W-1:0] free_reg, free_next;
    logic              failed_reg, failed_next;
    logic              pool_out_reg, pool_out_next;
    logic [SLOT_W-1:0] sweep_reg, sweep_next;
    logic              m_valid_reg, m_valid_next;

    // payload holding
    twd_req_t          item_reg;
    logic [SLOT_W-1:0] slot_reg;
    twd_res_t          m_res_reg, m_res_next;

    // table ports
    logic              child_wr_en, child_rd_en;
    logic [SLOT_W-1:0] child_wr_addr;
    logic [NODE_W-1:0] child_wr_data, child_rd_data;
    logic              mark_wr_en, mark_rd_en;
    logic [NODE_W-1:0] mark_wr_addr;
    logic              mark_wr_data, mark_rd_data;

    logic              letter_bad;
    logic [SLOT_W-1:0] in_slot;
    logic              pool_full;
    logic              item_insert, item_search;

    assign letter_bad  = (32'(s_req.letter) >= ALPHABET_SIZE);
    assign in_slot     = SLOT_W'(SLOT_W'(node_reg) * SLOT_W'(ALPHABET_SIZE))
                         + SLOT_W'(s_req.letter);
    assign pool_full   = (free_reg == POOL_W'(NODE_COUNT));
    assign item_insert = (item_reg.command == CMD_INSERT);
    assign item_search = (item_reg.command == CMD_SEARCH);

    always_comb begin
        node_next     = node_reg;
        free_next     = free_reg;
        failed_next   = failed_reg;
        pool_out_next = pool_out_reg;
        sweep_next    = sweep_reg;
        m_valid_next  = m_valid_reg;
        m_res_next    = m_res_reg;
        child_wr_en   = 1'b0;
        child_wr_addr = slot_reg;
        child_wr_data = free_reg[NODE_W-1:0];
        mark_wr_en    = 1'b0;
        mark_wr_addr  = node_reg;
        mark_wr_data  = 1'b1;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.sweep) begin
            child_wr_en   = 1'b1;
            child_wr_addr = sweep_reg;
            child_wr_data = '0;
            mark_wr_en    = (sweep_reg < SLOT_W'(NODE_COUNT));
            mark_wr_addr  = sweep_reg[NODE_W-1:0];
            mark_wr_data  = 1'b0;
            sweep_next    = sweep_reg + SLOT_W'(1);
        end

        if (cmd.accept && letter_bad) begin
            failed_next = 1'b1;
        end

        if (cmd.resolve) begin
            if (child_rd_data != '0) begin
                node_next = child_rd_data;
            end else if (item_insert) begin
                if (!pool_full) begin
                    // allocate the next pool node as the child
                    child_wr_en = 1'b1;
                    node_next   = free_reg[NODE_W-1:0];
                    free_next   = free_reg + POOL_W'(1);
                end else begin
                    pool_out_next = 1'b1;
                    failed_next   = 1'b1;
                end
            end else begin
                failed_next = 1'b1;
            end
        end

        if (cmd.commit) begin
            mark_wr_en   = item_insert && !failed_reg;
            m_valid_next = 1'b1;
            if (item_insert) begin
                m_res_next.hit      = 1'b0;
                m_res_next.overflow = pool_out_reg;
            end else if (item_search) begin
                m_res_next.hit      = !failed_reg && mark_rd_data;
                m_res_next.overflow = 1'b0;
            end else begin
                m_res_next.hit      = !failed_reg;
                m_res_next.overflow = 1'b0;
            end
            // back to the root for the next word
            node_next     = '0;
            failed_next   = 1'b0;
            pool_out_next = 1'b0;
        end
    end

    assign child_rd_en = cmd.accept && !status.in_skip;
    assign mark_rd_en  = cmd.resolve && item_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg     <= '0;
            free_reg     <= POOL_W'(1);
            failed_reg   <= 1'b0;
            pool_out_reg <= 1'b0;
            sweep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            node_reg     <= node_next;
            free_reg     <= free_next;
            failed_reg   <= failed_next;
            pool_out_reg <= pool_out_next;
            sweep_reg    <= sweep_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_req;
            slot_reg <= in_slot;
        end
        m_res_reg <= m_res_next;
    end

    twd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SLOTS)
    ) u_child_ram (
        .clk     (aclk),
        .wr_en   (child_wr_en),
        .wr_addr (child_wr_addr),
        .wr_data (child_wr_data),
        .rd_en   (child_rd_en),
        .rd_addr (in_slot),
        .rd_data (child_rd_data)
    );

    twd_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_mark_ram (
        .clk     (aclk),
        .wr_en   (mark_wr_en),
        .wr_addr (mark_wr_addr),
        .wr_data (mark_wr_data),
        .rd_en   (mark_rd_en),
        .rd_addr (node_next),
        .rd_data (mark_rd_data)
    );

    always_comb begin
        status.sweep_last = (sweep_reg == SLOT_W'(SLOTS - 1));
        status.in_skip    = failed_reg || letter_bad;
        status.in_last    = s_req.last;
        status.item_last  = item_reg.last;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule
`default_nettype wire

[hw/rtl/trie_word_dictionary_core.sv]
`default_nettype none
// ============================================================================
// trie_word_dictionary_core
// Dictionary trie over lowercase letters, fed one letter per request.
// ============================================================================
// Usage:
//   s_ channel: one request per letter, carrying the command (insert, exact
//   search, prefix test), the letter index and a last-letter mark. Every
//   letter walks one step down the trie from the node that the previous
//   letter reached; a new word starts at the root.
//   m_ channel: one result per last letter: hit (search or prefix found)
//   and overflow (insert ran out of free nodes).
// Sequence:
//   A letter first reads the child index from the child table, then steps or
//   allocates. A last letter then loads the result into the output register,
//   which raises m_valid; this waits while the previous result is unread.
//   A letter after a failed walk or outside the alphabet needs no table read
//   and skips the step-or-allocate stage; a last one still loads the result.
//   The registered child table read is why the lookup is a separate step.
// Reset:
//   After aresetn the tables are swept clear one entry a cycle, over all
//   NODE_COUNT * ALPHABET_SIZE entries (26624); s_ready stays low meanwhile.
// Stall:
//   A result waits in the output register while m_ready is low; further
//   letters are still accepted, and the next result holds until it is free.
// ============================================================================
module trie_word_dictionary_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire twd_pkg::twd_req_t s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output twd_pkg::twd_res_t      m_res
);
    import twd_pkg::*;

    twd_cmd_t    cmd;
    twd_status_t status;

    // sequencer: sweep, accept, resolve, commit
    twd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // walk registers, node tables and result register
    twd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res),
        .cmd     (cmd),
        .status  (status)
    );

endmodule
`default_nettype wire

[hw/rtl/twd_checker.sv]
`default_nettype none
// ============================================================================
// twd_checker
// Port-level checks of the dictionary trie, bound to the top level.
// ============================================================================
module twd_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire twd_pkg::twd_req_t s_req,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire twd_pkg::twd_res_t m_res
);

    // reset: no request taken, no result shown, clearing pass begins
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("request or result open right after reset");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("stalled result changed or dropped");

    // hit and overflow never both set: insert never hits, search and prefix never overflow
    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_res.hit && m_res.overflow))
        else $error("hit and overflow both set");

    // a result only follows a letter that carried the last mark
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_req.last && !m_valid |=> !m_valid)
        else $error("result without a last letter");

endmodule

bind trie_word_dictionary_core twd_checker u_checker (.*);
`default_nettype wire
